@@ rtl/sbapd_pkg.sv @@
package sbapd_pkg;

    // spectrum geometry
    localparam int BINS  = 512;
    localparam int BIN_W = $clog2(BINS);

    // field and register widths
    localparam int VALUE_W     = 32;
    localparam int PEAK_W      = 16;
    localparam int SHIFT_W     = 5;
    localparam int PERIOD_W    = 16;
    localparam int SIA_W       = 17;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // sum storage: high sum in the upper half, low sum in the lower half
    localparam int SUMS_W = 2 * VALUE_W;

    // register reset values and limits
    localparam logic [SHIFT_W-1:0]  MAX_SHIFT    = 5'd16;
    localparam logic [SHIFT_W-1:0]  RESET_SHIFT  = 5'd6;
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd2000;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_AVG_SHIFT         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_CLEAR_PERIOD = 2'd1;

    // result queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

@@ rtl/sbapd_ram.sv @@
module sbapd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/spectrum_block_averager_peak_decimator.sv @@
// Spectrum block averager with peak pass-through. Bins stream in one word per
// cycle; every accepted word yields exactly one result word, in order. Each bin
// position keeps a high sum (value >> avg_shift) and a low sum (value bits below
// the shift) in one 64-bit wide, BINS deep synchronous RAM; on the last spectrum
// of a block of 2^avg_shift spectra (shift capped at 16) the bin result is
// high + (low >> shift) and both sums restart at zero. Peaks pass through on
// spectra whose frame count is a multiple of the average length, and the final
// bin raises clear_peaks when the count reaches peak_clear_period. Throughput is
// one word per cycle while s_ready is high; words pass the registered add stage
// and the result queue to m_valid, with RAM forwarding between back-to-back
// words on the same bin. After reset a clearing pass zeroes all BINS entries
// (one a cycle) with s_ready low; configuration writes are taken meanwhile.
// Write registers only while the block is idle; the block does not enforce it.
module spectrum_block_averager_peak_decimator (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [sbapd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sbapd_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // bin input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sbapd_pkg::VALUE_W-1:0]       s_avg_value,
    input  logic [sbapd_pkg::PEAK_W-1:0]        s_peak_value,
    input  logic                                s_end_of_spectrum,

    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sbapd_pkg::VALUE_W-1:0]       m_bin_average,
    output logic                                m_average_valid,
    output logic [sbapd_pkg::PEAK_W-1:0]        m_bin_peak,
    output logic                                m_peak_valid,
    output logic                                m_spectrum_done,
    output logic                                m_clear_peaks
);

    // word in the read-modify-write stage
    typedef struct packed {
        logic [sbapd_pkg::BIN_W-1:0]   addr;
        logic [sbapd_pkg::VALUE_W-1:0] hi_part;
        logic [sbapd_pkg::VALUE_W-1:0] lo_part;
        logic [sbapd_pkg::SHIFT_W-1:0] shift;
        logic                          avg_done;
        logic                          peak_fwd;
        logic [sbapd_pkg::PEAK_W-1:0]  peak;
        logic                          done;
        logic                          clr;
        logic                          fwd;
        logic [sbapd_pkg::SUMS_W-1:0]  fwd_data;
    } stage_t;

    // result word
    typedef struct packed {
        logic [sbapd_pkg::VALUE_W-1:0] avg;
        logic                          avg_valid;
        logic [sbapd_pkg::PEAK_W-1:0]  peak;
        logic                          peak_valid;
        logic                          done;
        logic                          clr;
    } result_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [sbapd_pkg::SHIFT_W-1:0]  avg_shift_reg;
    logic [sbapd_pkg::PERIOD_W-1:0] peak_clear_period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_shift_reg         <= sbapd_pkg::RESET_SHIFT;
            peak_clear_period_reg <= sbapd_pkg::RESET_PERIOD;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sbapd_pkg::REG_AVG_SHIFT: begin
                    avg_shift_reg <= cfg_wdata[sbapd_pkg::SHIFT_W-1:0];
                end
                sbapd_pkg::REG_PEAK_CLEAR_PERIOD: begin
                    peak_clear_period_reg <= cfg_wdata[sbapd_pkg::PERIOD_W-1:0];
                end
                default: begin
                    // unknown index: write ignored
                end
            endcase
        end
    end

    // shift capped at sixteen, mask of the bits below it
    logic [sbapd_pkg::SHIFT_W-1:0] eff_shift;
    logic [sbapd_pkg::VALUE_W-1:0] avg_mask;

    assign eff_shift = (avg_shift_reg > sbapd_pkg::MAX_SHIFT) ? sbapd_pkg::MAX_SHIFT
                                                              : avg_shift_reg;
    assign avg_mask  = ~({sbapd_pkg::VALUE_W{1'b1}} << eff_shift);

    // ---------------------------------------------------------------
    // clearing pass after reset
    // ---------------------------------------------------------------
    logic                        clr_busy_reg;
    logic [sbapd_pkg::BIN_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == sbapd_pkg::BIN_W'(sbapd_pkg::BINS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // frame control at word acceptance
    // ---------------------------------------------------------------
    logic [sbapd_pkg::BIN_W-1:0]    bin_position_reg, bin_position_next;
    logic [sbapd_pkg::SIA_W-1:0]    spectra_in_average_reg, spectra_in_average_next;
    logic [sbapd_pkg::PERIOD_W-1:0] peak_frame_count_reg, peak_frame_count_next;
    logic [1:0]                     frame_flags_reg, frame_flags_next;

    logic                           in_accept;
    logic                           first_bin;
    logic                           last_bin;
    logic [sbapd_pkg::PERIOD_W-1:0] pfc_cur;
    logic [1:0]                     flags_cur;
    logic                           clr_hit;

    stage_t                         s1_reg, s1_next;
    logic                           s1_valid_reg;
    logic [sbapd_pkg::SUMS_W-1:0]   wr_sums;

    assign in_accept = s_valid && s_ready;
    assign first_bin = (bin_position_reg == '0);
    assign last_bin  = s_end_of_spectrum
                    || (bin_position_reg == sbapd_pkg::BIN_W'(sbapd_pkg::BINS - 1));

    always_comb begin
        // frame count advances on the first bin of each spectrum
        pfc_cur   = first_bin ? (peak_frame_count_reg + 1'b1) : peak_frame_count_reg;
        flags_cur = frame_flags_reg;
        if (first_bin) begin
            // bit 0: average completes, bit 1: peaks forwarded
            flags_cur[0] = (spectra_in_average_reg >= avg_mask[sbapd_pkg::SIA_W-1:0]);
            flags_cur[1] = ((pfc_cur & avg_mask[sbapd_pkg::PERIOD_W-1:0]) == '0);
        end
        clr_hit = last_bin && (pfc_cur >= peak_clear_period_reg);

        bin_position_next       = last_bin ? '0 : (bin_position_reg + 1'b1);
        frame_flags_next        = flags_cur;
        peak_frame_count_next   = clr_hit ? '0 : pfc_cur;
        spectra_in_average_next = spectra_in_average_reg;
        if (last_bin) begin
            spectra_in_average_next = flags_cur[0] ? '0 : (spectra_in_average_reg + 1'b1);
        end

        s1_next          = '0;
        s1_next.addr     = bin_position_reg;
        s1_next.hi_part  = s_avg_value >> eff_shift;
        s1_next.lo_part  = s_avg_value & avg_mask;
        s1_next.shift    = eff_shift;
        s1_next.avg_done = flags_cur[0];
        s1_next.peak_fwd = flags_cur[1];
        s1_next.peak     = s_peak_value;
        s1_next.done     = last_bin;
        s1_next.clr      = clr_hit;
        // same bin being written back this cycle: take its new sums
        s1_next.fwd      = s1_valid_reg && (s1_reg.addr == bin_position_reg);
        s1_next.fwd_data = wr_sums;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_position_reg       <= '0;
            spectra_in_average_reg <= '0;
            peak_frame_count_reg   <= '0;
            frame_flags_reg        <= '0;
        end else if (in_accept) begin
            bin_position_reg       <= bin_position_next;
            spectra_in_average_reg <= spectra_in_average_next;
            peak_frame_count_reg   <= peak_frame_count_next;
            frame_flags_reg        <= frame_flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_reg <= s1_next;
        end
    end

    // ---------------------------------------------------------------
    // sum memory: read at acceptance, then add and write back in the next cycle, not later
    // ---------------------------------------------------------------
    logic                         ram_wr_en;
    logic [sbapd_pkg::BIN_W-1:0]  ram_wr_addr;
    logic [sbapd_pkg::SUMS_W-1:0] ram_wr_data;
    logic [sbapd_pkg::SUMS_W-1:0] ram_rd_data;

    sbapd_ram #(
        .WIDTH (sbapd_pkg::SUMS_W),
        .DEPTH (sbapd_pkg::BINS)
    ) u_sums (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (bin_position_reg),
        .rd_data (ram_rd_data)
    );

    logic [sbapd_pkg::SUMS_W-1:0]  old_sums;
    logic [sbapd_pkg::VALUE_W-1:0] high_sum;
    logic [sbapd_pkg::VALUE_W-1:0] low_sum;
    result_t                       s1_result;

    always_comb begin
        old_sums = s1_reg.fwd ? s1_reg.fwd_data : ram_rd_data;
        high_sum = old_sums[sbapd_pkg::SUMS_W-1:sbapd_pkg::VALUE_W] + s1_reg.hi_part;
        low_sum  = old_sums[sbapd_pkg::VALUE_W-1:0] + s1_reg.lo_part;
        // completed average restarts both sums
        wr_sums  = s1_reg.avg_done ? '0 : {high_sum, low_sum};

        s1_result            = '0;
        s1_result.avg        = s1_reg.avg_done ? (high_sum + (low_sum >> s1_reg.shift)) : '0;
        s1_result.avg_valid  = s1_reg.avg_done;
        s1_result.peak       = s1_reg.peak_fwd ? s1_reg.peak : '0;
        s1_result.peak_valid = s1_reg.peak_fwd;
        s1_result.done       = s1_reg.done;
        s1_result.clr        = s1_reg.clr;
    end

    assign ram_wr_en   = clr_busy_reg || s1_valid_reg;
    assign ram_wr_addr = clr_busy_reg ? clr_addr_reg : s1_reg.addr;
    assign ram_wr_data = clr_busy_reg ? '0 : wr_sums;

    // ---------------------------------------------------------------
    // result queue: keeps the input moving while results wait
    // ---------------------------------------------------------------
    result_t                          fifo_mem [0:sbapd_pkg::FIFO_DEPTH-1];
    logic [sbapd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [sbapd_pkg::FIFO_CNT_W-1:0] fifo_count_reg;
    logic                             push, pop;
    logic [sbapd_pkg::FIFO_CNT_W:0]   in_flight;

    assign push = s1_valid_reg;
    assign pop  = m_valid && m_ready;

    // one slot per word in the add stage and in the queue
    assign in_flight = {1'b0, fifo_count_reg} + {{sbapd_pkg::FIFO_CNT_W{1'b0}}, s1_valid_reg};
    assign s_ready   = !clr_busy_reg
                    && (in_flight < (sbapd_pkg::FIFO_CNT_W + 1)'(sbapd_pkg::FIFO_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == sbapd_pkg::FIFO_PTR_W'(sbapd_pkg::FIFO_DEPTH - 1))
                            ? '0 : (wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == sbapd_pkg::FIFO_PTR_W'(sbapd_pkg::FIFO_DEPTH - 1))
                            ? '0 : (rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                fifo_count_reg <= fifo_count_reg + 1'b1;
            end else if (pop && !push) begin
                fifo_count_reg <= fifo_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= s1_result;
        end
    end

    assign m_valid         = (fifo_count_reg != '0);
    assign m_bin_average   = fifo_mem[rd_ptr_reg].avg;
    assign m_average_valid = fifo_mem[rd_ptr_reg].avg_valid;
    assign m_bin_peak      = fifo_mem[rd_ptr_reg].peak;
    assign m_peak_valid    = fifo_mem[rd_ptr_reg].peak_valid;
    assign m_spectrum_done = fifo_mem[rd_ptr_reg].done;
    assign m_clear_peaks   = fifo_mem[rd_ptr_reg].clr;

`ifndef NO_ASSERTIONS
    // the queue always has room for the word in the add stage
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (fifo_count_reg != sbapd_pkg::FIFO_CNT_W'(sbapd_pkg::FIFO_DEPTH)))
        else $error("result queue full with a word in the add stage");

    // a peak clear only comes with the final bin of a spectrum
    a_clear_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clear_peaks) |-> m_spectrum_done)
        else $error("clear_peaks without spectrum_done");

    // a marked final bin restarts the bin position
    a_bin_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_end_of_spectrum) |=> (bin_position_reg == '0))
        else $error("bin position not restarted after final bin");

    // no word enters before the clearing pass is over
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |=> !s1_valid_reg)
        else $error("word accepted during clearing pass");
`endif

endmodule
